// File: src/tfmt_pkg.sv
package tfmt_pkg;

	localparam int FLOW_ENTRIES_DEF = 8;
	localparam int PAIR_ENTRIES_DEF = 512;

	localparam logic [2:0] CLS_IPV4_OTHER = 3'd3;
	localparam logic [2:0] CLS_TCP = 3'd4;

	typedef struct packed {
		logic [2:0] packet_class;
		logic [15:0] ingress_port;
		logic [15:0] egress_port;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] pkt_mark;
		logic fin_or_rst;
		logic [15:0] pkt_len;
		logic [63:0] now_ns;
		logic [63:0] arrival_ns;
	} in_item_t;

	typedef struct packed {
		logic verdict;
		logic tracked;
		logic new_flow;
		logic overflow;
		logic [31:0] flow_packets;
		logic [31:0] flow_bytes;
		logic flow_finished;
		logic [31:0] pair_packets;
	} out_item_t;

	// Work handed from the flow stage to the pair stage.
	typedef struct packed {
		logic tracked;
		logic new_flow;
		logic overflow;
		logic [31:0] flow_packets;
		logic [31:0] flow_bytes;
		logic flow_finished;
		logic verdict;
		logic [31:0] pair_key;
		logic [15:0] pkt_len;
		logic [31:0] latency;
	} job_t;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_SCAN,
		PS_WAIT,
		PS_UPDATE,
		PS_OUT
	} pair_state_t;

endpackage

// File: src/tcp_flow_meter_table_unit.sv
// TCP flow meter with an exact-match flow cache and per-port-pair totals.
// Input channel: push with full; a transfer happens when push is high and
// full is low, carrying one parsed packet as in_item. Result channel: empty
// with pop; out_item holds the oldest result while empty is low and is
// transferred when pop is high. Every packet gives exactly one result.
// The flow stage looks up all flow entries in parallel and updates the
// flow table in the cycle of the transfer, then hands a job to the pair
// stage through a one-entry register. The pair stage scans its table one
// entry at a time, a read state then a compare state per entry, from the
// bottom up to its fill count, then does a read-modify-write. Non-TCP
// packets skip the scan and go straight to the output state.
// The flow stage accepts the next packet while the pair stage works.
// Reset clears the valid bits and the fill count; no clearing pass runs.
// A stalled result holds the pair stage, which then stalls the input.
module tcp_flow_meter_table_unit #(
	parameter int FLOW_ENTRIES = tfmt_pkg::FLOW_ENTRIES_DEF,
	parameter int PAIR_ENTRIES = tfmt_pkg::PAIR_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input tfmt_pkg::in_item_t in_item,
	output logic empty,
	input logic pop,
	output tfmt_pkg::out_item_t out_item
);

	logic job_valid, job_ready;
	tfmt_pkg::job_t job;

	tfmt_flow #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_flow (
		.clk, .arst_n, .push, .full, .in_item,
		.job_valid, .job_ready, .job
	);

	tfmt_pair #(.PAIR_ENTRIES(PAIR_ENTRIES)) u_pair (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.empty, .pop, .out_item
	);

endmodule

// File: src/tfmt_flow.sv
module tfmt_flow #(
	parameter int FLOW_ENTRIES = tfmt_pkg::FLOW_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input tfmt_pkg::in_item_t in_item,
	output logic job_valid,
	input logic job_ready,
	output tfmt_pkg::job_t job
);

	localparam int FW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

	logic [FLOW_ENTRIES-1:0] valid_q;
	logic [63:0] kp_q [FLOW_ENTRIES];
	logic [63:0] ka_q [FLOW_ENTRIES];
	logic [63:0] kl_q [FLOW_ENTRIES];
	logic [31:0] pkts_q [FLOW_ENTRIES];
	logic [31:0] bytes_q [FLOW_ENTRIES];
	logic [63:0] start_q [FLOW_ENTRIES];
	logic [63:0] end_q [FLOW_ENTRIES];
	logic done_q [FLOW_ENTRIES];

	logic [63:0] kp, ka, kl;
	logic [FLOW_ENTRIES-1:0] match;
	logic hit, has_free;
	logic [FW-1:0] hit_idx, free_idx;
	logic take;
	logic is_track;
	tfmt_pkg::job_t nj;
	logic [63:0] lat64;

	assign full = job_valid && !job_ready;
	assign take = push && !full;
	assign is_track = in_item.packet_class == tfmt_pkg::CLS_TCP;

	assign kp = {32'd0, in_item.ingress_port, in_item.egress_port};
	assign ka = {in_item.src_addr, in_item.dst_addr};
	assign kl = {in_item.src_port, in_item.dst_port, in_item.pkt_mark};

	always_comb begin
		hit = 1'b0;
		has_free = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && kp_q[i] == kp && ka_q[i] == ka && kl_q[i] == kl;
			if (match[i]) begin
				hit = 1'b1;
				hit_idx = FW'(i);
			end
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = FW'(i);
			end
		end
	end

	always_comb begin
		lat64 = in_item.now_ns - in_item.arrival_ns;
		nj = '0;
		nj.verdict = !(in_item.packet_class == tfmt_pkg::CLS_IPV4_OTHER || is_track);
		nj.tracked = is_track;
		nj.pair_key = {in_item.ingress_port, in_item.egress_port};
		nj.pkt_len = in_item.pkt_len;
		nj.latency = (in_item.arrival_ns != 64'd0) ? lat64[31:0] : 32'd0;
		if (is_track) begin
			if (hit) begin
				nj.flow_packets = pkts_q[hit_idx] + 32'd1;
				nj.flow_bytes = bytes_q[hit_idx] + {16'd0, in_item.pkt_len};
				nj.flow_finished = done_q[hit_idx] || in_item.fin_or_rst;
			end else if (has_free) begin
				nj.new_flow = 1'b1;
				nj.flow_packets = 32'd1;
				nj.flow_bytes = {16'd0, in_item.pkt_len};
				nj.flow_finished = in_item.fin_or_rst;
			end else begin
				nj.overflow = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= take || (job_valid && !job_ready);
			if (take) begin
				if (is_track && !hit && has_free) valid_q[free_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job <= nj;
			if (is_track && hit) begin
				pkts_q[hit_idx] <= nj.flow_packets;
				bytes_q[hit_idx] <= nj.flow_bytes;
				end_q[hit_idx] <= in_item.now_ns;
				done_q[hit_idx] <= nj.flow_finished;
			end else if (is_track && has_free) begin
				kp_q[free_idx] <= kp;
				ka_q[free_idx] <= ka;
				kl_q[free_idx] <= kl;
				pkts_q[free_idx] <= 32'd1;
				bytes_q[free_idx] <= nj.flow_bytes;
				start_q[free_idx] <= in_item.now_ns;
				end_q[free_idx] <= 64'd0;
				done_q[free_idx] <= in_item.fin_or_rst;
			end
		end
	end

`ifndef ASSERT_OFF
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(match))
		else $error("flow key stored twice");
	a_new_excl: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> !(job.new_flow && job.overflow))
		else $error("new flow and overflow together");
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) >= $countones($past(valid_q)))
		else $error("flow entry lost");
`endif

endmodule

// File: src/tfmt_pair.sv
module tfmt_pair #(
	parameter int PAIR_ENTRIES = tfmt_pkg::PAIR_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input tfmt_pkg::job_t job,
	output logic empty,
	input logic pop,
	output tfmt_pkg::out_item_t out_item
);

	localparam int PW = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
	localparam int CW = $clog2(PAIR_ENTRIES + 1);

	// Entries fill from the bottom and are never freed, so a fill count
	// stands in for the valid bits.
	logic [31:0] key_mem [PAIR_ENTRIES];
	logic [159:0] cnt_mem [PAIR_ENTRIES];
	logic [CW-1:0] fill_q;
	logic [CW-1:0] idx_q;
	logic [31:0] key_rd_q;
	logic [159:0] cnt_rd_q;
	tfmt_pkg::job_t job_q;
	tfmt_pkg::pair_state_t state_q, state_d;
	logic out_valid_q;
	tfmt_pkg::out_item_t out_q;
	logic found_q;
	logic [PW-1:0] found_idx_q;
	logic [31:0] pp_q;
	logic [PW-1:0] rd_idx;
	logic [159:0] wr_data;
	logic wr_en;
	logic [PW-1:0] wr_idx;
	logic [31:0] pp;
	logic [31:0] p_pk, p_by, p_op, p_ob, p_la;

	assign rd_idx = idx_q[PW-1:0];
	assign empty = !out_valid_q;
	assign out_item = out_q;
	assign job_ready = state_q == tfmt_pkg::PS_IDLE;

	always_comb begin
		{p_pk, p_by, p_op, p_ob, p_la} = cnt_rd_q;
		state_d = state_q;
		wr_en = 1'b0;
		wr_idx = found_idx_q;
		wr_data = '0;
		pp = 32'd0;
		unique case (state_q)
			tfmt_pkg::PS_IDLE: begin
				if (job_valid) state_d = job.tracked ? tfmt_pkg::PS_SCAN : tfmt_pkg::PS_OUT;
			end
			tfmt_pkg::PS_SCAN: begin
				if (idx_q >= fill_q) state_d = tfmt_pkg::PS_UPDATE;
				else state_d = tfmt_pkg::PS_WAIT;
			end
			tfmt_pkg::PS_WAIT: begin
				if (key_rd_q == job_q.pair_key) state_d = tfmt_pkg::PS_UPDATE;
				else state_d = tfmt_pkg::PS_SCAN;
			end
			tfmt_pkg::PS_UPDATE: begin
				state_d = tfmt_pkg::PS_OUT;
				if (found_q) begin
					wr_en = 1'b1;
					pp = p_pk + 32'd1;
					wr_data = {pp, p_by + {16'd0, job_q.pkt_len},
						p_op + {31'd0, job_q.overflow},
						p_ob + (job_q.overflow ? {16'd0, job_q.pkt_len} : 32'd0),
						p_la + job_q.latency};
				end else if (fill_q < CW'(PAIR_ENTRIES)) begin
					wr_en = 1'b1;
					wr_idx = fill_q[PW-1:0];
					pp = 32'd1;
					wr_data = {32'd1, 16'd0, job_q.pkt_len, 31'd0, job_q.overflow,
						job_q.overflow ? {16'd0, job_q.pkt_len} : 32'd0, job_q.latency};
				end
			end
			tfmt_pkg::PS_OUT: begin
				if (!out_valid_q || pop) state_d = tfmt_pkg::PS_IDLE;
			end
			default: state_d = tfmt_pkg::PS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tfmt_pkg::PS_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !pop) ||
				(state_q == tfmt_pkg::PS_OUT && (!out_valid_q || pop));
			unique case (state_q)
				tfmt_pkg::PS_IDLE: begin
					idx_q <= '0;
					found_q <= 1'b0;
				end
				tfmt_pkg::PS_SCAN: ;
				tfmt_pkg::PS_WAIT: begin
					if (key_rd_q == job_q.pair_key) found_q <= 1'b1;
					else idx_q <= idx_q + CW'(1);
				end
				tfmt_pkg::PS_UPDATE: begin
					if (!found_q && fill_q < CW'(PAIR_ENTRIES)) fill_q <= fill_q + CW'(1);
				end
				tfmt_pkg::PS_OUT: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tfmt_pkg::PS_IDLE && job_valid) begin
			job_q <= job;
		end
		if (state_q == tfmt_pkg::PS_SCAN) begin
			key_rd_q <= key_mem[rd_idx];
			cnt_rd_q <= cnt_mem[rd_idx];
			found_idx_q <= rd_idx;
		end
		if (wr_en) begin
			key_mem[wr_idx] <= job_q.pair_key;
			cnt_mem[wr_idx] <= wr_data;
		end
		if (state_q == tfmt_pkg::PS_UPDATE) begin
			pp_q <= pp;
		end
		if (state_q == tfmt_pkg::PS_OUT && (!out_valid_q || pop)) begin
			out_q.verdict <= job_q.verdict;
			out_q.tracked <= job_q.tracked;
			out_q.new_flow <= job_q.new_flow;
			out_q.overflow <= job_q.overflow;
			out_q.flow_packets <= job_q.flow_packets;
			out_q.flow_bytes <= job_q.flow_bytes;
			out_q.flow_finished <= job_q.flow_finished;
			out_q.pair_packets <= job_q.tracked ? pp_q : 32'd0;
		end
	end

`ifndef ASSERT_OFF
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(PAIR_ENTRIES))
		else $error("pair fill count beyond depth");
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tfmt_pkg::PS_WAIT |-> idx_q < fill_q)
		else $error("pair scan past fill");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> $past(state_q) == tfmt_pkg::PS_UPDATE)
		else $error("fill changed outside update");
`endif

endmodule
